// File: rtl/ked_pkg.sv
// ----------------------------------------------------------------------------
// Key event detector package
// Shared constants, flag bit positions and the structs that pass settings and
// per-beat control from the top level to the per-key cells.
// ----------------------------------------------------------------------------
package ked_pkg;

  localparam int unsigned NumKeys    = 4;
  localparam int unsigned KeyIdxW    = 2;
  localparam int unsigned FlagW      = 7;
  localparam int unsigned TimerW     = 16;
  localparam int unsigned PeriodW    = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // Event flag bit positions.
  localparam int unsigned EvHold   = 0;
  localparam int unsigned EvDown   = 1;
  localparam int unsigned EvUp     = 2;
  localparam int unsigned EvSingle = 3;
  localparam int unsigned EvDouble = 4;
  localparam int unsigned EvLong   = 5;
  localparam int unsigned EvRepeat = 6;

  localparam logic [FlagW-1:0] MaskHoldOnly = 7'h01;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegSamplePeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLongPress    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDoubleClick  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRepeat       = 2'd3;

  // Reset values of the registers.
  localparam logic [PeriodW-1:0] SamplePeriodRst = 8'd20;
  localparam logic [TimerW-1:0]  LongPressRst    = 16'd2000;
  localparam logic [TimerW-1:0]  DoubleClickRst  = 16'd200;
  localparam logic [TimerW-1:0]  RepeatRst       = 16'd100;

  // Commands.
  localparam logic CmdTick  = 1'b0;
  localparam logic CmdCheck = 1'b1;

  typedef struct packed {
    logic [TimerW-1:0] long_press_ticks;
    logic [TimerW-1:0] double_click_ticks;
    logic [TimerW-1:0] repeat_ticks;
  } ked_timing_t;

  typedef struct packed {
    logic             tick;    // count the timer down
    logic             sample;  // take a new level sample
    logic             clear;   // clear the masked flags
    logic [FlagW-1:0] mask;
  } ked_ctrl_t;

endpackage

// File: rtl/ked_key_cell.sv
// ----------------------------------------------------------------------------
// Key event detector: one key cell
// Holds one key's flags, level, click state and timer, and works out their
// next values for one tick or check beat.
// ----------------------------------------------------------------------------
module ked_key_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         update_i,
  input  ked_pkg::ked_ctrl_t           ctrl_i,
  input  ked_pkg::ked_timing_t         timing_i,
  input  logic                         level_i,
  output logic [ked_pkg::FlagW-1:0]    flags_o,
  output logic [ked_pkg::FlagW-1:0]    flags_next_o
);

  typedef enum logic [2:0] {
    StIdle     = 3'd0,
    StPressed  = 3'd1,
    StReleased = 3'd2,
    StDouble   = 3'd3,
    StLong     = 3'd4
  } click_state_e;

  click_state_e                      state_q, state_d;
  logic [ked_pkg::FlagW-1:0]         flags_q, flags_d;
  logic                              level_q, level_d;
  logic [ked_pkg::TimerW-1:0]        timer_q, timer_d;
  logic [ked_pkg::TimerW-1:0]        timer_dec;
  logic                              expired;

  always_comb begin
    timer_dec = timer_q;
    if (ctrl_i.tick && (timer_q != '0)) begin
      timer_dec = timer_q - ked_pkg::TimerW'(1);
    end
    expired = (timer_dec == '0);

    state_d = state_q;
    flags_d = flags_q;
    level_d = level_q;
    timer_d = timer_dec;

    if (ctrl_i.sample) begin
      level_d = level_i;
      flags_d[ked_pkg::EvHold] = level_i;
      if (level_i && !level_q) begin
        flags_d[ked_pkg::EvDown] = 1'b1;
      end
      if (!level_i && level_q) begin
        flags_d[ked_pkg::EvUp] = 1'b1;
      end

      unique case (state_q)
        StIdle: begin
          if (level_i) begin
            state_d = StPressed;
            timer_d = timing_i.long_press_ticks;
          end
        end
        StPressed: begin
          if (!level_i) begin
            state_d = StReleased;
            timer_d = timing_i.double_click_ticks;
          end else if (expired) begin
            state_d = StLong;
            timer_d = timing_i.repeat_ticks;
            flags_d[ked_pkg::EvLong] = 1'b1;
          end
        end
        StReleased: begin
          if (level_i) begin
            state_d = StDouble;
            flags_d[ked_pkg::EvDouble] = 1'b1;
          end else if (expired) begin
            state_d = StIdle;
            flags_d[ked_pkg::EvSingle] = 1'b1;
          end
        end
        StDouble: begin
          if (!level_i) begin
            state_d = StIdle;
          end
        end
        StLong: begin
          if (!level_i) begin
            state_d = StIdle;
          end else if (expired) begin
            flags_d[ked_pkg::EvRepeat] = 1'b1;
            timer_d = timing_i.repeat_ticks;
          end
        end
        default: begin
          state_d = StIdle;
        end
      endcase
    end

    if (ctrl_i.clear) begin
      flags_d = flags_q & ~ctrl_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      flags_q <= '0;
      level_q <= 1'b0;
      timer_q <= '0;
    end else if (update_i) begin
      state_q <= state_d;
      flags_q <= flags_d;
      level_q <= level_d;
      timer_q <= timer_d;
    end
  end

  assign flags_o      = flags_q;
  assign flags_next_o = flags_d;

endmodule

// File: rtl/key_event_detector.sv
// ----------------------------------------------------------------------------
// Key event detector
// Turns raw key levels into sticky per-key click, double-click, long-press
// and repeat event flags, and answers flag checks with clear-on-read.
// ----------------------------------------------------------------------------
// How the block is used:
// Items arrive on the input channel (in_valid_i / in_ready_o). A tick beat
// (command 0) counts every key's timer down and, once every sample_period
// ticks, samples key_levels_i and advances each key's click machine. A check
// beat (command 1) tests the flags of key key_index_i against event_mask_i,
// reports a hit, and clears the matched flags unless the mask is hold alone.
// Every beat gives exactly one result beat (out_valid_o / out_ready_i)
// carrying hit_o and the selected key's flags after the beat.
// An item passes through the input register, then the key cells update and
// the result register loads. One item is taken every cycle while the
// receiver takes results; the rate is set by the single pass through the
// per-key update logic, which handles all four keys in parallel.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more item, after which in_ready_o drops.
// Settings are written through cfg_valid_i / cfg_index_i / cfg_data_i, which
// is always ready; writes should be made while no item is in flight.
// Reset clears all flags, levels, timers and the tick count, sets every key's
// click machine to idle and loads the default settings.
// ----------------------------------------------------------------------------
module key_event_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [ked_pkg::NumKeys-1:0]   key_levels_i,
  input  logic [ked_pkg::KeyIdxW-1:0]   key_index_i,
  input  logic [ked_pkg::FlagW-1:0]     event_mask_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic [ked_pkg::FlagW-1:0]     key_flags_o,
  // Settings write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ked_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ked_pkg::CfgDataW-1:0]  cfg_data_i
);

  // Settings.
  logic [ked_pkg::PeriodW-1:0] sample_period_q;
  ked_pkg::ked_timing_t        timing_q;

  // Input register.
  logic                          s1_valid_q;
  logic                          s1_cmd_q;
  logic [ked_pkg::NumKeys-1:0]   s1_levels_q;
  logic [ked_pkg::KeyIdxW-1:0]   s1_idx_q;
  logic [ked_pkg::FlagW-1:0]     s1_mask_q;

  // Result register.
  logic                          out_valid_q;
  logic                          hit_q, hit_d;
  logic [ked_pkg::FlagW-1:0]     key_flags_q;

  logic [ked_pkg::PeriodW-1:0]   tick_count_q, tick_count_d, tick_inc;

  logic                          s1_advance;
  logic                          in_accept;
  logic                          is_tick, is_check, do_sample, do_clear;

  logic [ked_pkg::FlagW-1:0]     flags    [ked_pkg::NumKeys];
  logic [ked_pkg::FlagW-1:0]     flags_nx [ked_pkg::NumKeys];
  ked_pkg::ked_ctrl_t            ctrl     [ked_pkg::NumKeys];

  // The result register frees up when empty or when its beat is taken.
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_accept  = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign is_tick  = (s1_cmd_q == ked_pkg::CmdTick);
  assign is_check = (s1_cmd_q == ked_pkg::CmdCheck);

  // Tick counter: eight bits wide, it restarts from zero at each sample.
  always_comb begin
    tick_inc     = tick_count_q + ked_pkg::PeriodW'(1);
    do_sample    = is_tick && (tick_inc >= sample_period_q);
    tick_count_d = do_sample ? '0 : tick_inc;
  end

  // A check hits if any masked flag of the selected key is set; the hold
  // bit alone is tested without clearing it.
  assign hit_d    = is_check && ((flags[s1_idx_q] & s1_mask_q) != '0);
  assign do_clear = hit_d && (s1_mask_q != ked_pkg::MaskHoldOnly);

  for (genvar k = 0; k < ked_pkg::NumKeys; k++) begin : g_key
    assign ctrl[k].tick   = is_tick;
    assign ctrl[k].sample = do_sample;
    assign ctrl[k].clear  = do_clear && (s1_idx_q == ked_pkg::KeyIdxW'(k));
    assign ctrl[k].mask   = s1_mask_q;

    ked_key_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .update_i     (s1_advance),
      .ctrl_i       (ctrl[k]),
      .timing_i     (timing_q),
      .level_i      (s1_levels_q[k]),
      .flags_o      (flags[k]),
      .flags_next_o (flags_nx[k])
    );
  end

  // Settings registers; an index outside the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_period_q             <= ked_pkg::SamplePeriodRst;
      timing_q.long_press_ticks   <= ked_pkg::LongPressRst;
      timing_q.double_click_ticks <= ked_pkg::DoubleClickRst;
      timing_q.repeat_ticks       <= ked_pkg::RepeatRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ked_pkg::RegSamplePeriod: begin
          sample_period_q <= cfg_data_i[ked_pkg::PeriodW-1:0];
        end
        ked_pkg::RegLongPress: begin
          timing_q.long_press_ticks <= cfg_data_i;
        end
        ked_pkg::RegDoubleClick: begin
          timing_q.double_click_ticks <= cfg_data_i;
        end
        ked_pkg::RegRepeat: begin
          timing_q.repeat_ticks <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state of both stages and the tick counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      tick_count_q <= '0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (s1_advance && is_tick) begin
        tick_count_q <= tick_count_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q    <= command_i;
      s1_levels_q <= key_levels_i;
      s1_idx_q    <= key_index_i;
      s1_mask_q   <= event_mask_i;
    end
    if (s1_advance) begin
      hit_q       <= hit_d;
      key_flags_q <= flags_nx[s1_idx_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign key_flags_o = key_flags_q;

endmodule
